[rtl/btn_pkg.sv]
package btn_pkg;

  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned PageWidth  = 32;
  localparam int unsigned FieldIdxW  = 3;
  localparam int unsigned InDataW    = 136;
  localparam int unsigned OutDataW   = 40;

  typedef enum logic [2:0] {
    OP_INIT      = 3'd0,
    OP_FIND      = 3'd1,
    OP_INSERT    = 3'd2,
    OP_UPDATE    = 3'd3,
    OP_GET_CHILD = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_READ,
    S_UPD_CHECK,
    S_SHIFT,
    S_SHIFT_WR,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [KeyWidth-1:0]  key;
    logic [PageWidth-1:0] page;
  } cell_t;

endpackage

[rtl/btn_cell_ram.sv]
module btn_cell_ram
  import btn_pkg::*;
#(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = 2
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  cell_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output cell_t         rd_data
);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, rd_data holds its value until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/btree_internal_node_table.sv]
// channel  | dir | handshake                    | payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready | opcode, search_key, new_key, child_page,
//          |     |                              | right_max_key, child_slot
// m_axis   | out | m_axis_tvalid / m_axis_tready | status, found_index, found_page, key_count
//
// one request at a time; init and full or append inserts go straight to the result, get_child
// reads at most one cell, find and update read one cell per binary search step plus at most
// one final read, a searched insert also reads and writes each shifted cell, all set by the
// single read port of the cell memory
// rst clears key count, right child, fsm and output valid; the cell memory is not
// cleared, only cells below the key count are ever read
// a finished result waits in the output register, the next request is taken meanwhile
module btree_internal_node_table
  import btn_pkg::*;
#(
  parameter int unsigned MAX_CELLS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // opcode[2:0], search_key[34:3], new_key[66:35], child_page[98:67],
  // right_max_key[130:99], child_slot[133:131], zero fill [135:134]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status[1:0], found_index[4:2], found_page[36:5], key_count[39:37]
  output logic [OutDataW-1:0] m_axis_tdata
);

  // address, count and extended widths
  localparam int unsigned AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned CW = $clog2(MAX_CELLS + 1);
  localparam int unsigned XW = (CW > FieldIdxW) ? CW : FieldIdxW;

  // request fields
  opcode_t               in_op;
  logic [KeyWidth-1:0]   in_skey;
  logic [KeyWidth-1:0]   in_nkey;
  logic [PageWidth-1:0]  in_cpage;
  logic [KeyWidth-1:0]   in_rmax;
  logic [FieldIdxW-1:0]  in_cidx;

  assign in_op    = opcode_t'(s_axis_tdata[2:0]);
  assign in_skey  = s_axis_tdata[34:3];
  assign in_nkey  = s_axis_tdata[66:35];
  assign in_cpage = s_axis_tdata[98:67];
  assign in_rmax  = s_axis_tdata[130:99];
  assign in_cidx  = s_axis_tdata[133:131];

  // control state
  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [PageWidth-1:0]  right_page, right_page_next;

  // latched request
  opcode_t               op, op_next;
  logic [KeyWidth-1:0]   skey, skey_next;
  logic [KeyWidth-1:0]   nkey, nkey_next;
  logic [PageWidth-1:0]  cpage, cpage_next;

  // search bounds, hi doubles as the shift pointer during insert
  logic [CW-1:0]         lo, lo_next;
  logic [CW-1:0]         hi, hi_next;
  logic [CW-1:0]         mid;

  // pending result
  status_t               res_status, res_status_next;
  logic [FieldIdxW-1:0]  res_idx, res_idx_next;
  logic [PageWidth-1:0]  res_page, res_page_next;

  logic                  out_valid_next;
  logic [OutDataW-1:0]   out_data_next;

  // memory port
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  cell_t                 wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  cell_t                 rd_data;

  logic [XW-1:0]         cidx_x;
  logic [XW-1:0]         count_x;
  logic [XW-1:0]         lo_x;
  logic [CW-1:0]         hi_dec;
  logic                  out_free;

  assign mid      = lo + ((hi - lo) >> 1);
  assign cidx_x   = XW'(in_cidx);
  assign count_x  = XW'(count);
  assign lo_x     = XW'(lo);
  assign hi_dec   = hi - CW'(1);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);

  btn_cell_ram #(
    .DEPTH (MAX_CELLS),
    .AW    (AW)
  ) u_cells (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      right_page    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      right_page    <= right_page_next;
      m_axis_tvalid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op           <= op_next;
    skey         <= skey_next;
    nkey         <= nkey_next;
    cpage        <= cpage_next;
    lo           <= lo_next;
    hi           <= hi_next;
    res_status   <= res_status_next;
    res_idx      <= res_idx_next;
    res_page     <= res_page_next;
    m_axis_tdata <= out_data_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    right_page_next = right_page;
    op_next         = op;
    skey_next       = skey;
    nkey_next       = nkey;
    cpage_next      = cpage;
    lo_next         = lo;
    hi_next         = hi;
    res_status_next = res_status;
    res_idx_next    = res_idx;
    res_page_next   = res_page;
    out_valid_next  = m_axis_tvalid && !m_axis_tready;
    out_data_next   = m_axis_tdata;
    wr_en           = 1'b0;
    wr_addr         = count[AW-1:0];
    wr_data         = '{key: skey, page: cpage};
    rd_en           = 1'b0;
    rd_addr         = mid[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_next         = in_op;
          skey_next       = in_skey;
          nkey_next       = in_nkey;
          cpage_next      = in_cpage;
          lo_next         = '0;
          hi_next         = count;
          res_status_next = ST_OK;
          res_idx_next    = '0;
          res_page_next   = '0;
          state_next      = S_RESULT;
          unique case (in_op)
            OP_INIT: begin
              count_next      = '0;
              right_page_next = in_cpage;
            end
            OP_FIND, OP_UPDATE: begin
              state_next = S_SEARCH;
            end
            OP_INSERT: begin
              priority if (count >= CW'(MAX_CELLS)) begin
                res_status_next = ST_FULL;
              end else if (in_skey > in_rmax) begin
                // old right child becomes the new last cell
                wr_en           = 1'b1;
                wr_addr         = count[AW-1:0];
                wr_data         = '{key: in_rmax, page: right_page};
                right_page_next = in_cpage;
                count_next      = count + CW'(1);
                res_idx_next    = count_x[FieldIdxW-1:0];
                res_page_next   = in_cpage;
              end else begin
                state_next = S_SEARCH;
              end
            end
            OP_GET_CHILD: begin
              res_idx_next = in_cidx;
              priority if (cidx_x > count_x) begin
                res_status_next = ST_RANGE;
              end else if (cidx_x == count_x) begin
                res_page_next = right_page;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = cidx_x[AW-1:0];
                state_next = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (lo != hi) begin
          rd_en      = 1'b1;
          rd_addr    = mid[AW-1:0];
          state_next = S_COMPARE;
        end else begin
          res_idx_next = lo_x[FieldIdxW-1:0];
          unique case (op)
            OP_INSERT: begin
              // shift pointer starts at the first free cell
              hi_next    = count;
              state_next = S_SHIFT;
            end
            OP_UPDATE: begin
              if (lo < count) begin
                rd_en      = 1'b1;
                rd_addr    = lo[AW-1:0];
                state_next = S_UPD_CHECK;
              end else begin
                res_status_next = ST_NOT_FOUND;
                res_idx_next    = '0;
                state_next      = S_RESULT;
              end
            end
            default: begin
              // find
              if (lo < count) begin
                rd_en      = 1'b1;
                rd_addr    = lo[AW-1:0];
                state_next = S_READ;
              end else begin
                res_page_next = right_page;
                state_next    = S_RESULT;
              end
            end
          endcase
        end
      end

      S_COMPARE: begin
        if (rd_data.key >= skey) begin
          hi_next = mid;
        end else begin
          lo_next = mid + CW'(1);
        end
        state_next = S_SEARCH;
      end

      S_READ: begin
        res_page_next = rd_data.page;
        state_next    = S_RESULT;
      end

      S_UPD_CHECK: begin
        if (rd_data.key == skey) begin
          wr_en         = 1'b1;
          wr_addr       = lo[AW-1:0];
          wr_data       = '{key: nkey, page: rd_data.page};
          res_page_next = rd_data.page;
        end else begin
          res_status_next = ST_NOT_FOUND;
          res_idx_next    = '0;
        end
        state_next = S_RESULT;
      end

      S_SHIFT: begin
        if (hi > lo) begin
          rd_en      = 1'b1;
          rd_addr    = hi_dec[AW-1:0];
          state_next = S_SHIFT_WR;
        end else begin
          // gap is open at lo
          wr_en         = 1'b1;
          wr_addr       = lo[AW-1:0];
          wr_data       = '{key: skey, page: cpage};
          count_next    = count + CW'(1);
          res_page_next = cpage;
          state_next    = S_RESULT;
        end
      end

      S_SHIFT_WR: begin
        wr_en      = 1'b1;
        wr_addr    = hi[AW-1:0];
        wr_data    = rd_data;
        hi_next    = hi_dec;
        state_next = S_SHIFT;
      end

      S_RESULT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = {count_x[FieldIdxW-1:0], res_page, res_idx, res_status};
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // node never holds more keys than cells
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_CELLS))
    else $error("key count above node capacity");

  // search window stays inside the used cells
  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH || state == S_COMPARE) |-> (lo <= hi && hi <= count))
    else $error("search bounds out of order");

  // cell writes only land inside the memory
  a_write_addr: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (AW'(wr_addr) < AW'(MAX_CELLS) || MAX_CELLS == (1 << AW)))
    else $error("cell write beyond node capacity");

  // a result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT && m_axis_tvalid && !m_axis_tready) |=> (state == S_RESULT))
    else $error("result dropped while output stalled");

endmodule

[tb/btree_node_checker.sv]
`timescale 1ns / 100ps

// watches both channels, keeps its own copy of the node and compares every reply
module btree_node_checker
  import btn_pkg::*;
#(
  parameter int unsigned MAX_CELLS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_ready,
  input  logic [InDataW-1:0]  req_data,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  logic [OutDataW-1:0] rsp_data,
  output int                  mismatch_count,
  output int                  replies_open
);

  typedef struct packed {
    status_t                status;
    logic [FieldIdxW-1:0]   idx;
    logic [PageWidth-1:0]   page;
    logic [FieldIdxW-1:0]   count;
  } node_reply_t;

  // shadow copy of the node
  logic [FieldIdxW-1:0] key_cnt;
  logic [KeyWidth-1:0]  cell_keys  [MAX_CELLS];
  logic [PageWidth-1:0] cell_pages [MAX_CELLS];
  logic [PageWidth-1:0] right_pg;

  node_reply_t replies_due[$];

  // first cell whose key is at or above the given key, key_cnt if none
  function automatic int unsigned lower_bound_pos(input logic [KeyWidth-1:0] k);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = key_cnt;
    while (lo != hi) begin
      mid = lo + (hi - lo) / 2;
      if (cell_keys[mid] >= k) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  function automatic logic [PageWidth-1:0] page_at(input int unsigned pos);
    if (pos < key_cnt) return cell_pages[pos];
    return right_pg;
  endfunction

  function automatic node_reply_t apply_node_op(input logic [InDataW-1:0] req);
    logic [2:0]           op;
    logic [KeyWidth-1:0]  skey;
    logic [KeyWidth-1:0]  nkey;
    logic [PageWidth-1:0] cpage;
    logic [KeyWidth-1:0]  rmax;
    logic [FieldIdxW-1:0] cidx;
    node_reply_t          r;
    int unsigned          pos;
    int unsigned          i;
    op    = req[2:0];
    skey  = req[34:3];
    nkey  = req[66:35];
    cpage = req[98:67];
    rmax  = req[130:99];
    cidx  = req[133:131];
    r.status = ST_OK;
    r.idx    = '0;
    r.page   = '0;
    case (op)
      OP_INIT: begin
        key_cnt  = '0;
        right_pg = cpage;
      end
      OP_FIND: begin
        pos    = lower_bound_pos(skey);
        r.idx  = FieldIdxW'(pos);
        r.page = page_at(pos);
      end
      OP_INSERT: begin
        if (key_cnt >= MAX_CELLS) begin
          r.status = ST_FULL;
        end else begin
          if (skey > rmax) begin
            // old right child becomes the new last cell
            pos             = key_cnt;
            cell_pages[pos] = right_pg;
            cell_keys[pos]  = rmax;
            right_pg        = cpage;
          end else begin
            pos = lower_bound_pos(skey);
            for (i = key_cnt; i > pos; i--) begin
              cell_keys[i]  = cell_keys[i-1];
              cell_pages[i] = cell_pages[i-1];
            end
            cell_keys[pos]  = skey;
            cell_pages[pos] = cpage;
          end
          key_cnt = key_cnt + 1'b1;
          r.idx   = FieldIdxW'(pos);
          r.page  = cpage;
        end
      end
      OP_UPDATE: begin
        pos = lower_bound_pos(skey);
        if (pos < key_cnt && cell_keys[pos] == skey) begin
          cell_keys[pos] = nkey;
          r.idx          = FieldIdxW'(pos);
          r.page         = cell_pages[pos];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_GET_CHILD: begin
        r.idx = cidx;
        if (cidx > key_cnt) r.status = ST_RANGE;
        else r.page = page_at(cidx);
      end
      default: ;
    endcase
    r.count = key_cnt;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    node_reply_t want;
    if (rst) begin
      key_cnt  = '0;
      right_pg = '0;
      replies_due.delete();
    end else begin
      // reply first: a request taken at the same edge cannot have answered yet
      if (rsp_valid && rsp_ready) begin
        if (replies_due.size() == 0) begin
          $error("reply with no request outstanding: 0x%0h", rsp_data);
          mismatch_count++;
        end else begin
          want = replies_due.pop_front();
          compare_field("status", 32'(want.status), 32'(rsp_data[1:0]));
          compare_field("found_index", 32'(want.idx), 32'(rsp_data[4:2]));
          compare_field("found_page", want.page, rsp_data[36:5]);
          compare_field("key_count", 32'(want.count), 32'(rsp_data[39:37]));
        end
      end
      if (req_valid && req_ready) replies_due.push_back(apply_node_op(req_data));
    end
    replies_open = replies_due.size();
  end

endmodule

[tb/btree_internal_node_table_test.sv]
`timescale 1ns / 100ps

// stimulus and verdict for the node table; all checking lives in btree_node_checker
module btree_internal_node_table_test;
  import btn_pkg::*;

  localparam int unsigned NodeCells   = 4;
  localparam int unsigned RandomReqs  = 900;
  // far above the slowest legal run: ~925 requests, each with the block's own work
  // plus random gaps on both sides
  localparam int unsigned CycleLimit  = 400000;
  // block latency is well under this, longest insert shifts every cell
  localparam int unsigned DrainCycles = 40;
  // opcodes past the last defined one, the block must answer and change nothing
  localparam logic [2:0]  OpUnusedLo  = 3'd5;
  localparam logic [2:0]  OpUnusedHi  = 3'd7;
  localparam logic [KeyWidth-1:0] KeyMax = '1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // opcode, search_key, new_key, child_page, right_max_key, child_slot, zero fill
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // status, found_index, found_page, key_count
  logic [OutDataW-1:0] m_axis_tdata;

  int          mismatch_count;
  int          replies_open;
  int unsigned cycles = 0;
  // when set neither side idles
  bit          steady = 1'b0;

  btree_internal_node_table #(
    .MAX_CELLS(NodeCells)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  btree_node_checker #(
    .MAX_CELLS(NodeCells)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (s_axis_tvalid),
    .req_ready     (s_axis_tready),
    .req_data      (s_axis_tdata),
    .rsp_valid     (m_axis_tvalid),
    .rsp_ready     (m_axis_tready),
    .rsp_data      (m_axis_tdata),
    .mismatch_count(mismatch_count),
    .replies_open  (replies_open)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // reply side back-pressure, about a quarter of the cycles stalled
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= steady || ($urandom_range(99) >= 26);
  end

  function automatic logic [InDataW-1:0] pack_request(
    input logic [2:0]           op,
    input logic [KeyWidth-1:0]  skey,
    input logic [KeyWidth-1:0]  nkey,
    input logic [PageWidth-1:0] cpage,
    input logic [KeyWidth-1:0]  rmax,
    input logic [FieldIdxW-1:0] cidx
  );
    return {2'b00, cidx, rmax, cpage, nkey, skey, op};
  endfunction

  // present one request, with random idle cycles ahead of it, and return on
  // the edge at which it is taken; tready is looked at on the falling edge
  task automatic offer(input logic [InDataW-1:0] req);
    while (!steady && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= req;
    s_axis_tvalid <= 1'b1;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
  endtask

  task automatic node_req(
    input logic [2:0]           op,
    input logic [KeyWidth-1:0]  skey,
    input logic [KeyWidth-1:0]  nkey,
    input logic [PageWidth-1:0] cpage,
    input logic [KeyWidth-1:0]  rmax,
    input logic [FieldIdxW-1:0] cidx
  );
    offer(pack_request(op, skey, nkey, cpage, rmax, cidx));
  endtask

  // hold the request side low until every outstanding reply is back
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (replies_open != 0);
    @(posedge clk);
  endtask

  // small keys collide often, so updates hit and inserts interleave;
  // the rest are extremes and full-width values
  function automatic logic [KeyWidth-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) return KeyWidth'($urandom_range(24));
    if (roll < 72) return KeyMax;
    if (roll < 76) return '0;
    if (roll < 79) return KeyMax - 1'b1;
    return $urandom;
  endfunction

  // weighted opcode mix: enough inserts per init that the node fills up
  function automatic logic [2:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 6)  return OP_INIT;
    if (roll < 30) return OP_FIND;
    if (roll < 62) return OP_INSERT;
    if (roll < 76) return OP_UPDATE;
    if (roll < 94) return OP_GET_CHILD;
    return 3'($urandom_range(OpUnusedHi, OpUnusedLo));
  endfunction

  function automatic logic [FieldIdxW-1:0] pick_index();
    if ($urandom_range(99) < 85) return FieldIdxW'($urandom_range(NodeCells));
    return FieldIdxW'($urandom_range(7));
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty node, every path of insert, full node, lookups at the edges
    node_req(OP_INIT, '0, '0, KeyMax, '0, '0);
    node_req(OP_FIND, 32'd7, '0, '0, '0, '0);             // empty node gives right child
    node_req(OP_GET_CHILD, '0, '0, '0, '0, 3'd0);         // index 0 is the right child
    node_req(OP_GET_CHILD, '0, '0, '0, '0, 3'd1);         // past the key count
    node_req(OP_UPDATE, 32'd5, 32'd9, '0, '0, '0);        // nothing to update
    node_req(OP_INSERT, 32'd10, '0, 32'hA5A5_0001, 32'd5, '0);  // right child moves down
    node_req(OP_INSERT, 32'd3, '0, 32'h5A5A_0002, 32'd20, '0);  // shifts one cell up
    node_req(OP_INSERT, '0, '0, 32'h0000_0003, '0, '0);         // lowest key, equal max
    node_req(OP_INSERT, KeyMax, '0, 32'hFFFF_0004, KeyMax, '0); // top key, placed last
    node_req(OP_INSERT, 32'd1, '0, 32'h1234_5678, KeyMax, '0);  // node full
    node_req(OP_FIND, '0, '0, '0, '0, '0);
    node_req(OP_FIND, KeyMax, '0, '0, '0, '0);
    node_req(OP_FIND, 32'd4, '0, '0, '0, '0);
    node_req(OP_UPDATE, 32'd3, KeyMax - 1'b1, '0, '0, '0);  // exact hit
    node_req(OP_UPDATE, 32'd99, '0, '0, '0, '0);            // between keys, no hit
    node_req(OP_GET_CHILD, '0, '0, '0, '0, 3'd4);           // equal to count: right child
    node_req(OP_GET_CHILD, '0, '0, '0, '0, 3'd3);
    node_req(OP_GET_CHILD, '0, '0, '0, '0, 3'd7);
    node_req(OpUnusedLo, KeyMax, KeyMax, KeyMax, KeyMax, 3'd7);
    node_req(OpUnusedHi, '0, '0, '0, '0, '0);
    node_req(OP_INIT, '0, '0, '0, '0, '0);
    node_req(OP_INSERT, KeyMax, '0, KeyMax, '0, '0);        // append on a fresh node
    drain_replies();

    // random traffic with a stretch free of stalls and a few full drains
    for (int unsigned n = 0; n < RandomReqs; n++) begin
      if (n == 300) steady = 1'b1;
      if (n == 450) steady = 1'b0;
      if (n % 250 == 125) drain_replies();
      offer(pack_request(pick_op(), pick_key(), pick_key(), $urandom, pick_key(),
                         pick_index()));
    end

    drain_replies();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
